[hdl/lzw_compressor_defines.svh]
// Assertion macros shared by the LZW compressor RTL.
// Depends on nothing; included by the top level only.
`ifndef LZW_COMPRESSOR_DEFINES_SVH
`define LZW_COMPRESSOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LZWC_ASSERT_ON(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge, reset included.
`define LZWC_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lzwc_pkg.sv]
// Package of the LZW compressor: constants, engine states and shared structs.
// Depends on nothing; imported by every module of the block but lzwc_ram.
`timescale 1ns / 1ps
`default_nettype none
package lzwc_pkg;

    localparam int DICT_SIZE_DEF = 4096;
    localparam int CODE_W        = 12;
    localparam int BYTE_W        = 8;
    localparam int NEXT_W        = 13;
    localparam int EPOCH_W       = 8;
    localparam int FIRST_FREE    = 256;
    localparam int CODE_SPACE    = 4096;
    localparam int ENTRY_W       = EPOCH_W + CODE_W + BYTE_W + CODE_W;

    // One input word as held in the queue.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_item;

    // Status from the engine back to the front end.
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MISS,
        S_FINAL
    } t_state;

endpackage
`default_nettype wire

[hdl/lzw_compressor.sv]
// LZW compressor, 12-bit codes; depends on lzwc_pkg, lzwc_front, lzwc_back and the defines.
// The engine pops a byte only when idle and finishes its lookup before it pops the next;
// a stream's first byte needs no lookup, a miss adds a state to send its code, and
// the stream end adds a closing code; each hash collision adds one more probe.
// Reset: synchronous, active low; then a sweep over every table slot clears the table,
// repeated after every 255 streams, while no byte is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_compressor_defines.svh"
module lzw_compressor
    import lzwc_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [11:0] code, [15:12] zero
    output logic             m_axis_tlast    // final_code
);

    logic              w_q_valid, w_q_pop;
    t_item             w_q_item;
    t_back_stat        w_stat;
    logic [CODE_W-1:0] w_code;

    lzwc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_stream (s_axis_tlast),
        .i_stat          (w_stat),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_q_pop         (w_q_pop)
    );

    lzwc_back #(
        .DICT_SIZE (DICT_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .o_stat        (w_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_code        (w_code),
        .o_final_code  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_code};

    // The input stays closed while the dictionary is swept.
    `LZWC_ASSERT_ON(a_clear_closed, i_clk, i_rst_n, w_stat.clearing, !s_axis_tready, "input open during sweep")
    // No word is offered right after reset.
    `LZWC_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid && !s_axis_tready, "busy after reset")
    // The engine only pops a word the queue holds.
    `LZWC_ASSERT_ON(a_pop_valid, i_clk, i_rst_n, w_q_pop, w_q_valid, "pop from empty queue")

endmodule
`default_nettype wire

[hdl/lzwc_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write when enabled, read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

[hdl/lzwc_front.sv]
// Front end of the LZW compressor: accepts input words into a two-entry queue.
// Depends on lzwc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_front
    import lzwc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_end_of_stream,
    input  wire t_back_stat        i_stat,
    output logic                   o_q_valid,
    output t_item                  o_q_item,
    input  wire logic              i_q_pop
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    // No word is taken while the dictionary is being swept.
    assign s_axis_tready = (r_cnt != 2'd2) && !i_stat.clearing;
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign o_q_item      = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{data_byte: i_data_byte, end_of_stream: i_end_of_stream};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule
`default_nettype wire

[hdl/lzwc_back.sv]
// Back end of the LZW compressor: hashed dictionary engine and output register.
// Depends on lzwc_pkg and lzwc_ram.
`timescale 1ns / 1ps
`default_nettype none
module lzwc_back
    import lzwc_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_item             i_q_item,
    output logic                   o_q_pop,
    output t_back_stat             o_stat,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [CODE_W-1:0]      o_code,
    output logic                   o_final_code
);

    // Hash table of twice the dictionary size, so a probe always meets a free slot.
    localparam int HA    = $clog2(DICT_SIZE) + 1;
    localparam int LIMIT = (DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE;

    t_state              r_state, n_state;
    logic [CODE_W-1:0]   r_prefix, n_prefix;
    logic                r_pvalid, n_pvalid;
    logic [NEXT_W-1:0]   r_next, n_next;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [HA-1:0]       r_addr, n_addr;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_eos, n_eos;
    logic                r_out_valid, n_out_valid;
    logic [CODE_W-1:0]   r_out_code, n_out_code;
    logic                r_out_last, n_out_last;

    logic                w_we;
    logic [HA-1:0]       w_addr;
    logic [ENTRY_W-1:0]  w_wdata, w_rdata;
    logic [31:0]         w_key;
    logic [HA-1:0]       w_hash;
    logic                w_out_free;
    logic [EPOCH_W-1:0]  w_rd_epoch;
    logic [CODE_W-1:0]   w_rd_prefix, w_rd_code;
    logic [BYTE_W-1:0]   w_rd_byte;

    lzwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2**HA)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Slot layout, top down: epoch, prefix, byte, code.
    assign {w_rd_epoch, w_rd_prefix, w_rd_byte, w_rd_code} = w_rdata;

    // Fold the pair key of the current prefix and the queued byte into a slot index.
    assign w_key  = {12'd0, i_q_item.data_byte, r_prefix};
    assign w_hash = w_key[HA-1:0] ^ HA'(w_key >> HA);

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_stat        = '{clearing: (r_state == S_CLEAR)};
    assign m_axis_tvalid = r_out_valid;
    assign o_code        = r_out_code;
    assign o_final_code  = r_out_last;

    // State and data registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_prefix    <= '0;
            r_pvalid    <= 1'b0;
            r_next      <= NEXT_W'(FIRST_FREE);
            r_epoch     <= EPOCH_W'(1);
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prefix    <= n_prefix;
            r_pvalid    <= n_pvalid;
            r_next      <= n_next;
            r_epoch     <= n_epoch;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_eos      <= n_eos;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    // Next state and dictionary access.
    always_comb begin
        n_state     = r_state;
        n_prefix    = r_prefix;
        n_pvalid    = r_pvalid;
        n_next      = r_next;
        n_epoch     = r_epoch;
        n_addr      = r_addr;
        n_byte      = r_byte;
        n_eos       = r_eos;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_addr      = r_addr;
        w_wdata     = '0;
        unique case (r_state)
            S_CLEAR: begin
                // Sweep every slot to the empty epoch.
                w_we   = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_byte  = i_q_item.data_byte;
                    n_eos   = i_q_item.end_of_stream;
                    if (!r_pvalid) begin
                        n_prefix = CODE_W'(i_q_item.data_byte);
                        n_pvalid = 1'b1;
                        if (i_q_item.end_of_stream) begin
                            n_state = S_FINAL;
                        end
                    end else begin
                        w_addr  = w_hash;
                        n_addr  = w_hash;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_rd_epoch == r_epoch) begin
                    if (w_rd_prefix == r_prefix && w_rd_byte == r_byte) begin
                        n_prefix = w_rd_code;
                        n_state  = r_eos ? S_FINAL : S_IDLE;
                    end else begin
                        // Occupied by another pair: probe the next slot.
                        n_addr = r_addr + 1'b1;
                        w_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_prefix;
                    n_out_last  = 1'b0;
                    if (r_next < NEXT_W'(LIMIT)) begin
                        w_we    = 1'b1;
                        w_wdata = {r_epoch, r_prefix, r_byte, r_next[CODE_W-1:0]};
                        n_next  = r_next + 1'b1;
                    end
                    n_prefix = CODE_W'(r_byte);
                    n_state  = r_eos ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_prefix;
                    n_out_last  = 1'b1;
                    n_prefix    = '0;
                    n_pvalid    = 1'b0;
                    n_next      = NEXT_W'(FIRST_FREE);
                    // A new epoch empties the dictionary; on wrap the table is swept.
                    if (r_epoch == '1) begin
                        n_epoch = EPOCH_W'(1);
                        n_addr  = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule
`default_nettype wire
